// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the point cloud core.
// Included by modules that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Property that must also hold while reset is asserted.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== rtl/core/d2pc_pkg.sv =====
// Types and constants of the depth to point cloud core.
// No dependencies.
package d2pc_pkg;
  localparam int unsigned MaxWidth  = 4096;
  localparam int unsigned MaxHeight = 4096;
  localparam int unsigned DivBits   = 72;
  localparam int unsigned DenBits   = 50;
  localparam int unsigned QuoBits   = 31;
  localparam int unsigned DivSteps  = 4;
  localparam int unsigned DivStages = DivBits / DivSteps;
  localparam logic [30:0] QCap      = 31'h4000_0000;
  localparam logic [24:0] OneQ24    = 25'h100_0000;

  typedef enum logic [2:0] {
    RegNear   = 3'd0,
    RegFar    = 3'd1,
    RegFocal  = 3'd2,
    RegWidth  = 3'd3,
    RegHeight = 3'd4,
    RegColour = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [23:0] near_plane;
    logic [23:0] far_plane;
    logic [23:0] focal_length;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic        colored_mode;
  } cfg_t;

  // Side payload that travels next to the arithmetic.
  typedef struct packed {
    logic signed [13:0] col_off;
    logic signed [13:0] row_off;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } side_t;

  // One restoring division step: shift in a bit, subtract if possible.
  typedef struct packed {
    logic [DenBits:0]   rem;
    logic [QuoBits-1:0] quo;
  } div_st_t;

  // With cap set the quotient is capped at 2^30; without it only the low
  // quotient bits are kept.
  function automatic div_st_t div_step(div_st_t s, logic b, logic [DenBits-1:0] dv,
                                       logic cap);
    div_st_t            r;
    logic [DenBits+1:0] sh;
    logic [QuoBits:0]   q;
    sh = {s.rem, b};
    q  = {s.quo, 1'b0};
    if (sh >= {2'b00, dv}) begin
      sh = sh - {2'b00, dv};
      q[0] = 1'b1;
    end
    if (cap && (q > {1'b0, QCap})) begin
      q = {1'b0, QCap};
    end
    r.rem = sh[DenBits:0];
    r.quo = q[QuoBits-1:0];
    return r;
  endfunction
endpackage

// ===== rtl/core/depth_to_point_cloud_core.sv =====
// Top level of the depth to point cloud core: front end, z divider,
// lateral multipliers and dividers. Depends on d2pc_pkg, d2pc_cfg, d2pc_div.
//
//  channel   handshake            payload
//  input     start / busy         depth_code_i column_i row_i red/green/blue_in_i
//  result    valid_o (strobe)     x/y/z_pos_o red/green/blue_out_o
//  config    cfg_we_i             cfg_idx_i cfg_data_i
//
// One item per cycle; busy stays low, nothing ever stalls.
// Pipeline: 2 front-end stages, 18 stages of the z divider,
// 1 z saturation stage, 1 multiply stage, 18 stages of the lateral dividers
// and 1 output stage.
// Background pixels flow through with a cleared valid bit.
// Reset clears valid bits and loads the register reset values.
module depth_to_point_cloud_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [23:0]        cfg_data_i,
  input  logic [24:0]        depth_code_i,
  input  logic [11:0]        column_i,
  input  logic [11:0]        row_i,
  input  logic [7:0]         red_in_i,
  input  logic [7:0]         green_in_i,
  input  logic [7:0]         blue_in_i,
  output logic               valid_o,
  output logic signed [31:0] x_pos_o,
  output logic signed [31:0] y_pos_o,
  output logic signed [24:0] z_pos_o,
  output logic [7:0]         red_out_o,
  output logic [7:0]         green_out_o,
  output logic [7:0]         blue_out_o
);
  import d2pc_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned SideW = $bits(side_t);

  cfg_t cfg;
  d2pc_cfg u_cfg (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .cfg_o(cfg)
  );

  assign busy = 1'b0;
  logic acc;
  assign acc = start & ~busy;

  // Stage 1: register the item, clip the image size, form offsets.
  logic        v1_q;
  logic [23:0] d1_q;
  side_t       s1_q;
  logic [12:0] w_c, h_c;
  always_comb begin
    w_c = (cfg.image_width > 13'(MaxWidth)) ? 13'(MaxWidth) : cfg.image_width;
    h_c = (cfg.image_height > 13'(MaxHeight)) ? 13'(MaxHeight) : cfg.image_height;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= acc && (depth_code_i < OneQ24);
  end
  always_ff @(posedge clk_i) begin
    d1_q       <= depth_code_i[23:0];
    s1_q.col_off <= $signed({2'b00, column_i}) - $signed({2'b00, w_c[12:1]});
    s1_q.row_off <= $signed({2'b00, row_i}) - $signed({2'b00, h_c[12:1]});
    s1_q.red   <= cfg.colored_mode ? red_in_i : 8'd0;
    s1_q.green <= cfg.colored_mode ? green_in_i : 8'd0;
    s1_q.blue  <= cfg.colored_mode ? blue_in_i : 8'd0;
  end

  // Stage 2: denominator d*(f-n) - f*2^24 and numerator f*n.
  logic               v2_q;
  logic signed [50:0] den2_q;
  logic [47:0]        prod2_q;
  side_t              s2_q;
  logic signed [24:0] fmn;
  assign fmn = $signed({1'b0, cfg.far_plane}) - $signed({1'b0, cfg.near_plane});
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    den2_q  <= 51'($signed({1'b0, d1_q}) * fmn) - $signed({3'b000, cfg.far_plane, 24'd0});
    prod2_q <= cfg.far_plane * cfg.near_plane;
    s2_q    <= s1_q;
  end

  // z divider, with the sign and zero flags carried alongside.
  logic [DenBits-1:0] dmag;
  assign dmag = den2_q[50] ? 50'(-den2_q) : den2_q[49:0];
  logic [SideW+1:0]   zin;
  logic [QuoBits-1:0] zq;
  assign zin = {den2_q[50], (den2_q == '0), s2_q};
  d2pc_div u_zdiv (
    .clk_i, .en_i(1'b1), .cap_i(1'b1), .num_i({prod2_q, 24'd0}), .den_i(dmag),
    .quo_o(zq)
  );

  // Valid bits and side payload that keep pace with the z divider.
  logic [DivStages-1:0] zv_q;
  logic [SideW+1:0]     zd_q [DivStages];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) zv_q <= '0;
    else         zv_q <= {zv_q[DivStages-2:0], v2_q};
  end
  always_ff @(posedge clk_i) begin
    zd_q[0] <= zin;
    for (int i = 1; i < DivStages; i++) begin
      zd_q[i] <= zd_q[i-1];
    end
  end

  // Stage 3: saturate z.
  logic               v4_q;
  logic signed [24:0] z4_q;
  side_t              s4_q;
  side_t              zs;
  logic               zneg, zzero;
  assign {zneg, zzero, zs} = zd_q[DivStages-1];
  logic [24:0] zvec;
  always_comb begin
    if (zzero)      zvec = 25'h100_0000;
    else if (zneg)  zvec = (zq > 31'h100_0000) ? 25'h100_0000 : 25'(-zq);
    else            zvec = (zq > 31'hFF_FFFF) ? 25'hFF_FFFF : zq[24:0];
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else         v4_q <= zv_q[DivStages-1];
  end
  always_ff @(posedge clk_i) begin
    z4_q <= zvec;
    s4_q <= zs;
  end

  // Stage 4: -(offset*z), magnitude shifted by 8.
  logic               v5_q;
  logic signed [24:0] z5_q;
  logic [46:0]        xm5_q, ym5_q;
  logic               xn5_q, yn5_q;
  logic [23:0]        rgb5_q;
  logic signed [38:0] xp, yp;
  assign xp = -(s4_q.col_off * z4_q);
  assign yp = -(s4_q.row_off * z4_q);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else         v5_q <= v4_q;
  end
  always_ff @(posedge clk_i) begin
    z5_q   <= z4_q;
    xn5_q  <= xp[38];
    yn5_q  <= yp[38];
    xm5_q  <= {(xp[38] ? 39'(-xp) : xp), 8'd0};
    ym5_q  <= {(yp[38] ? 39'(-yp) : yp), 8'd0};
    rgb5_q <= {s4_q.red, s4_q.green, s4_q.blue};
  end

  // A quotient of 2^31 or more saturates, so it is found up front as
  // mag >= 2^31 * focal; the dividers then only need the low quotient bits.
  logic [55:0] lim;
  logic        bx, by, xz, yz;
  assign lim = {1'b0, cfg.focal_length, 31'd0};
  assign bx  = {9'd0, xm5_q} >= lim;
  assign by  = {9'd0, ym5_q} >= lim;
  assign xz  = (xm5_q == '0);
  assign yz  = (ym5_q == '0);

  // Lateral dividers by the focal length.
  localparam int unsigned LatW = 25 + 24 + 6;
  logic [LatW-1:0]    lin;
  logic [QuoBits-1:0] xq, yq;
  assign lin = {z5_q, rgb5_q, xn5_q, yn5_q, xz, yz, bx, by};
  d2pc_div u_xdiv (
    .clk_i, .en_i(1'b1), .cap_i(1'b0), .num_i({25'd0, xm5_q}),
    .den_i({26'd0, cfg.focal_length}), .quo_o(xq)
  );
  d2pc_div u_ydiv (
    .clk_i, .en_i(1'b1), .cap_i(1'b0), .num_i({25'd0, ym5_q}),
    .den_i({26'd0, cfg.focal_length}), .quo_o(yq)
  );

  // Valid bits and side payload that keep pace with the lateral dividers.
  logic [DivStages-1:0] lv_q;
  logic [LatW-1:0]      ld_q [DivStages];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) lv_q <= '0;
    else         lv_q <= {lv_q[DivStages-2:0], v5_q};
  end
  always_ff @(posedge clk_i) begin
    ld_q[0] <= lin;
    for (int i = 1; i < DivStages; i++) begin
      ld_q[i] <= ld_q[i-1];
    end
  end

  // Stage 5: saturation to 32 bits.
  logic               lxn, lyn, lxz, lyz, lbx, lby;
  logic signed [24:0] lz;
  logic [23:0]        lrgb;
  assign {lz, lrgb, lxn, lyn, lxz, lyz, lbx, lby} = ld_q[DivStages-1];

  function automatic logic [31:0] sat(logic neg, logic mz, logic [30:0] q,
                                      logic big, logic zf);
    logic [31:0] r;
    if (mz)               r = 32'd0;
    else if (zf)          r = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else if (neg)         r = big ? 32'h8000_0000 : 32'(-{1'b0, q});
    else                  r = (big || q == 31'h7FFF_FFFF) ? 32'h7FFF_FFFF : {1'b0, q};
    return r;
  endfunction
  logic fz;
  assign fz = (cfg.focal_length == '0);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else         valid_o <= lv_q[DivStages-1];
  end
  always_ff @(posedge clk_i) begin
    x_pos_o     <= sat(lxn, lxz, xq, lbx, fz);
    y_pos_o     <= sat(lyn, lyz, yq, lby, fz);
    z_pos_o     <= lz;
    red_out_o   <= lrgb[23:16];
    green_out_o <= lrgb[15:8];
    blue_out_o  <= lrgb[7:0];
  end

  `ASSERT_ALWAYS(a_never_busy, clk_i, !busy, "core reported busy")
  `ASSERT_IMPL(a_bg_dropped, clk_i, rst_ni,
    (start && depth_code_i >= OneQ24) |=> !v1_q, "background item entered pipeline")
  `ASSERT_IMPL(a_z_nonpos, clk_i, rst_ni, valid_o |-> !(z_pos_o > 0),
    "positive z delivered")
endmodule

// ===== rtl/core/d2pc_div.sv =====
// Pipelined restoring divider of a 72-bit dividend by a 50-bit divisor,
// quotient optionally capped at 2^30; depends on d2pc_pkg. One result per cycle while en_i is high.
module d2pc_div (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic                         cap_i,
  input  logic [d2pc_pkg::DivBits-1:0] num_i,
  input  logic [d2pc_pkg::DenBits-1:0] den_i,
  output logic [d2pc_pkg::QuoBits-1:0] quo_o
);
  import d2pc_pkg::*;

  div_st_t            st_q  [DivStages];
  logic [DivBits-1:0] num_q [DivStages];
  logic [DenBits-1:0] den_q [DivStages];

  // Four quotient bits per stage, dividend consumed from the top.
  for (genvar g = 0; g < DivStages; g++) begin : g_stage
    div_st_t            s_in;
    div_st_t            s_d;
    logic [DivBits-1:0] n_in;
    logic [DenBits-1:0] d_in;
    if (g == 0) begin : g_first
      assign s_in = '0;
      assign n_in = num_i;
      assign d_in = den_i;
    end else begin : g_next
      assign s_in = st_q[g-1];
      assign n_in = num_q[g-1];
      assign d_in = den_q[g-1];
    end
    always_comb begin
      s_d = s_in;
      for (int k = 0; k < DivSteps; k++) begin
        s_d = div_step(s_d, n_in[DivBits-1-g*DivSteps-k], d_in, cap_i);
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[g]  <= s_d;
        num_q[g] <= n_in;
        den_q[g] <= d_in;
      end
    end
  end

  assign quo_o = st_q[DivStages-1].quo;
endmodule

// ===== rtl/core/d2pc_cfg.sv =====
// Configuration register bank of the point cloud core.
// Depends on d2pc_pkg.
module d2pc_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [23:0]        cfg_data_i,
  output d2pc_pkg::cfg_t     cfg_o
);
  import d2pc_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Decode the register index; unknown indexes are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        RegNear:   cfg_d.near_plane   = cfg_data_i;
        RegFar:    cfg_d.far_plane    = cfg_data_i;
        RegFocal:  cfg_d.focal_length = cfg_data_i;
        RegWidth:  cfg_d.image_width  = cfg_data_i[12:0];
        RegHeight: cfg_d.image_height = cfg_data_i[12:0];
        RegColour: cfg_d.colored_mode = cfg_data_i[0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.near_plane   <= 24'd6554;
      cfg_q.far_plane    <= 24'd655360;
      cfg_q.focal_length <= 24'd128000;
      cfg_q.image_width  <= 13'd640;
      cfg_q.image_height <= 13'd480;
      cfg_q.colored_mode <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;
endmodule

// ===== test/depth_to_point_cloud_checker.sv =====
// Checker for the depth to point cloud core: predicts each 3-D point from the
// accepted pixels and compares it with the emitted points. Depends on d2pc_pkg.
module depth_to_point_cloud_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [23:0]        cfg_data_i,
  input  logic [24:0]        depth_code_i,
  input  logic [11:0]        column_i,
  input  logic [11:0]        row_i,
  input  logic [7:0]         red_in_i,
  input  logic [7:0]         green_in_i,
  input  logic [7:0]         blue_in_i,
  input  logic               valid_i,
  input  logic signed [31:0] x_pos_i,
  input  logic signed [31:0] y_pos_i,
  input  logic signed [24:0] z_pos_i,
  input  logic [7:0]         red_out_i,
  input  logic [7:0]         green_out_i,
  input  logic [7:0]         blue_out_i,
  output int                 fail_count_o,
  output int                 points_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import d2pc_pkg::*;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [24:0] z;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } point_t;

  cfg_t   cam;
  point_t expected_points[$];

  // Lateral coordinate: -(offset * z) * 256 / focal, truncated, saturated to 32 bits.
  function automatic logic signed [31:0] lateral_pos(longint offset, longint z,
                                                     longint unsigned focal);
    longint          p;
    bit              neg;
    longint unsigned mag;
    longint unsigned q;
    p   = -(offset * z);
    neg = p < 0;
    mag = longint'(neg ? -p : p) << 8;
    if (mag == 0) return 32'sd0;
    q = (focal == 0) ? (64'd1 << 32) : mag / focal;
    if (neg) return (q >= 64'd2147483648) ? 32'sh8000_0000 : 32'(-longint'(q));
    return (q >= 64'd2147483647) ? 32'sh7fff_ffff : 32'(longint'(q));
  endfunction

  // Unprojects one pixel with the current camera settings.
  function automatic point_t unproject(logic [24:0] d, logic [11:0] col, logic [11:0] row,
                                       logic [7:0] r, logic [7:0] g, logic [7:0] b);
    point_t          pt;
    longint          fr, nr, den, z, w, h;
    longint unsigned dmag, rem, q;
    logic [47:0]     fn;
    logic [71:0]     num;
    fr  = longint'(cam.far_plane);
    nr  = longint'(cam.near_plane);
    w   = (cam.image_width > MaxWidth) ? MaxWidth : cam.image_width;
    h   = (cam.image_height > MaxHeight) ? MaxHeight : cam.image_height;
    den = longint'(d) * (fr - nr) - (fr <<< 24);
    fn  = 48'(cam.far_plane) * 48'(cam.near_plane);
    num = {fn, 24'd0};
    if (den == 0) begin
      z = -16777216;
    end else begin
      // Restoring division with the quotient capped on every step.
      dmag = (den < 0) ? -den : den;
      rem  = 0;
      q    = 0;
      for (int k = 71; k >= 0; k--) begin
        rem = (rem << 1) | num[k];
        q   = q << 1;
        if (rem >= dmag) begin
          rem = rem - dmag;
          q   = q | 1;
        end
        if (q > 64'd1073741824) q = 64'd1073741824;
      end
      if (den < 0) z = (q > 64'd16777216) ? -16777216 : -longint'(q);
      else z = (q > 64'd16777215) ? 16777215 : longint'(q);
    end
    pt.x     = lateral_pos(longint'(col) - w / 2, z, cam.focal_length);
    pt.y     = lateral_pos(longint'(row) - h / 2, z, cam.focal_length);
    pt.z     = z[24:0];
    pt.red   = cam.colored_mode ? r : 8'd0;
    pt.green = cam.colored_mode ? g : 8'd0;
    pt.blue  = cam.colored_mode ? b : 8'd0;
    return pt;
  endfunction

  // Register copy, prediction on accepted pixels and comparison of points.
  always @(posedge clk_i or negedge rst_ni) begin
    point_t want;
    if (!rst_ni) begin
      cam.near_plane   = 24'd6554;
      cam.far_plane    = 24'd655360;
      cam.focal_length = 24'd128000;
      cam.image_width  = 13'd640;
      cam.image_height = 13'd480;
      cam.colored_mode = 1'b0;
      expected_points.delete();
      fail_count_o     = 0;
    end else begin
      if (valid_i) begin
        if (expected_points.size() == 0) begin
          $display("%0t: point with none expected: x %0d y %0d z %0d", $time,
                   x_pos_i, y_pos_i, z_pos_i);
          fail_count_o++;
        end else begin
          want = expected_points.pop_front();
          if (want != {x_pos_i, y_pos_i, z_pos_i, red_out_i, green_out_i, blue_out_i}) begin
            $display("%0t: point mismatch: expected x %0d y %0d z %0d rgb %0d %0d %0d",
                     $time, want.x, want.y, want.z, want.red, want.green, want.blue);
            $display("%0t:                 actual   x %0d y %0d z %0d rgb %0d %0d %0d",
                     $time, x_pos_i, y_pos_i, z_pos_i, red_out_i, green_out_i, blue_out_i);
            fail_count_o++;
          end
        end
      end
      if (start_i && !busy_i && depth_code_i < OneQ24) begin
        expected_points.insert(expected_points.size(),
                               unproject(depth_code_i, column_i, row_i,
                                         red_in_i, green_in_i, blue_in_i));
      end
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          RegNear:   cam.near_plane   = cfg_data_i;
          RegFar:    cam.far_plane    = cfg_data_i;
          RegFocal:  cam.focal_length = cfg_data_i;
          RegWidth:  cam.image_width  = cfg_data_i[12:0];
          RegHeight: cam.image_height = cfg_data_i[12:0];
          RegColour: cam.colored_mode = cfg_data_i[0];
          default: ;
        endcase
      end
    end
    points_pending_o = expected_points.size();
  end
endmodule

// ===== test/depth_to_point_cloud_core_tb.sv =====
// Testbench top of the depth to point cloud core: drives pixels and camera
// settings and gives the verdict. Depends on d2pc_pkg and the checker module.
module depth_to_point_cloud_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import d2pc_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = '0;
  logic [23:0]        cfg_data_i = '0;
  logic [24:0]        depth_code_i = '0;
  logic [11:0]        column_i = '0;
  logic [11:0]        row_i = '0;
  logic [7:0]         red_in_i = '0;
  logic [7:0]         green_in_i = '0;
  logic [7:0]         blue_in_i = '0;
  logic               valid_o;
  logic signed [31:0] x_pos_o;
  logic signed [31:0] y_pos_o;
  logic signed [24:0] z_pos_o;
  logic [7:0]         red_out_o;
  logic [7:0]         green_out_o;
  logic [7:0]         blue_out_o;
  int                 fail_count;
  int                 points_pending;
  bit                 burst_mode;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  depth_to_point_cloud_core DUT (.*);

  depth_to_point_cloud_checker u_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .depth_code_i, .column_i, .row_i, .red_in_i, .green_in_i, .blue_in_i,
    .valid_i(valid_o), .x_pos_i(x_pos_o), .y_pos_i(y_pos_o), .z_pos_i(z_pos_o),
    .red_out_i(red_out_o), .green_out_i(green_out_o), .blue_out_i(blue_out_o),
    .fail_count_o(fail_count), .points_pending_o(points_pending)
  );

  // Presents one pixel after a random gap (none in burst mode) and holds it until accepted.
  task automatic send_pixel(logic [24:0] d, logic [11:0] col, logic [11:0] row);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(15);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    depth_code_i = d;
    column_i     = col;
    row_i        = row;
    red_in_i     = 8'($urandom);
    green_in_i   = 8'($urandom);
    blue_in_i    = 8'($urandom);
    start        = 1'b1;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  // Waits for the pipeline to drain, then writes one camera register.
  task automatic write_reg(reg_idx_e idx, logic [23:0] data);
    start = 1'b0;
    wait (points_pending == 0);
    repeat (30) @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // A random pixel: mostly valid depths at random positions, some background.
  task automatic random_pixel();
    logic [24:0] d;
    int          pick;
    pick = $urandom_range(31);
    if (pick == 0) d = OneQ24;
    else if (pick == 1) d = 25'($urandom_range(25'h1ff_ffff, 25'h100_0001));
    else if (pick == 2) d = 25'd0;
    else if (pick == 3) d = OneQ24 - 25'd1;
    else d = 25'($urandom_range(24'hff_ffff));
    send_pixel(d, 12'($urandom_range(4095)), 12'($urandom_range(4095)));
  endtask

  initial begin
    #1000000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed pixels under the reset settings: depth extremes, background,
    // depth beyond one, image corners and centre.
    burst_mode = 1'b0;
    send_pixel(25'd0, 12'd0, 12'd0);
    send_pixel(OneQ24 - 25'd1, 12'd4095, 12'd4095);
    send_pixel(OneQ24, 12'd10, 12'd10);
    send_pixel(25'h1ff_ffff, 12'd20, 12'd20);
    send_pixel(25'h80_0000, 12'd320, 12'd240);
    send_pixel(25'h55_5555, 12'd639, 12'd0);
    send_pixel(25'haa_aaaa, 12'd0, 12'd479);

    // Colour on, with zero focal length and oversized image.
    write_reg(RegColour, 24'd1);
    write_reg(RegFocal, 24'd0);
    write_reg(RegWidth, 24'd8191);
    write_reg(RegHeight, 24'd4096);
    send_pixel(25'd12345, 12'd0, 12'd4095);
    send_pixel(25'h7f_ffff, 12'd2048, 12'd2048);
    send_pixel(OneQ24 - 25'd1, 12'd4095, 12'd0);

    // Bad plane order and the widest planes.
    write_reg(RegNear, 24'hff_ffff);
    write_reg(RegFar, 24'd1);
    write_reg(RegFocal, 24'd1);
    write_reg(RegWidth, 24'd1);
    write_reg(RegHeight, 24'd1);
    send_pixel(25'd0, 12'd0, 12'd0);
    send_pixel(OneQ24 - 25'd1, 12'd4095, 12'd4095);
    send_pixel(25'h12_3456, 12'd1, 12'd1);
    write_reg(RegNear, 24'd1);
    write_reg(RegFar, 24'hff_ffff);
    write_reg(RegFocal, 24'hff_ffff);
    send_pixel(25'd0, 12'd4095, 12'd0);
    send_pixel(OneQ24 - 25'd1, 12'd0, 12'd4095);
    send_pixel(25'h00_0001, 12'd7, 12'd3000);

    // Random phases, each with fresh settings and some with extremes.
    for (int phase = 0; phase < 6; phase++) begin
      int near_v;
      near_v = (phase == 0) ? 1 : $urandom_range(24'h10_0000, 1);
      write_reg(RegNear, 24'(near_v));
      write_reg(RegFar, (phase == 1) ? 24'hff_ffff :
                        24'($urandom_range(24'hff_ffff, near_v + 1)));
      write_reg(RegFocal, (phase == 2) ? 24'd1 : 24'($urandom_range(24'hff_ffff, 24'd256)));
      write_reg(RegWidth, (phase == 3) ? 24'd4096 : 24'($urandom_range(4096, 1)));
      write_reg(RegHeight, (phase == 4) ? 24'd1 : 24'($urandom_range(4096, 1)));
      write_reg(RegColour, 24'(phase % 2));
      for (int i = 0; i < 100; i++) begin
        if (i % 25 == 0) burst_mode = 1'($urandom_range(1));
        random_pixel();
      end
    end
    burst_mode = 1'b0;
    start      = 1'b0;

    wait (points_pending == 0);
    repeat (40) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
